// ----- rtl/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared types, sizes and constants of the Poisson tridiagonal solver.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int FRAC_BITS  = 28;
    localparam int QW         = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [QW-1:0] Q_ONE = QW'(1) <<< FRAC_BITS;
    localparam logic signed [QW-1:0] Q_TWO = QW'(2) <<< FRAC_BITS;
    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic signed [31:0] rhs_sample;
        logic               last_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic               last_value;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] rhs;
        logic               store;
        logic               last;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_D,
        ST_DIV_K,
        ST_WRITE,
        ST_BACK_RD,
        ST_BACK_START,
        ST_BACK_DIV,
        ST_BACK_OUT
    } state_t;

    function automatic logic signed [QW-1:0] sat34(input logic signed [33:0] v);
        logic signed [QW-1:0] r;
        begin
            if (v > 34'(signed'(Q_MAX))) r = Q_MAX;
            else if (v < 34'(signed'(Q_MIN))) r = Q_MIN;
            else r = v[QW-1:0];
            return r;
        end
    endfunction

endpackage

// ----- rtl/pts_front.sv -----
// ----------------------------------------------------------------------------
// Tridiagonal solver front end
// Accepts samples, decides whether each one is stored, and queues commands.
// ----------------------------------------------------------------------------
module pts_front (
    input  logic              clk,
    input  logic              rst_n,
    input  pts_pkg::in_item_t item,
    input  logic              push,
    output logic              full,
    output pts_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  logic              cmd_take
);
    import pts_pkg::*;

    cmd_t            q_reg [QUEUE_DEPTH];
    logic [0:0]      wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic            acc;

    assign full      = (cnt_reg == 2'(QUEUE_DEPTH));
    assign acc       = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (acc)
        begin
            if (item.last_sample) fill_next = '0;
            else if (fill_reg != CNT_W'(MAX_POINTS)) fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wp_reg].rhs   <= item.rhs_sample;
            q_reg[wp_reg].store <= (fill_reg != CNT_W'(MAX_POINTS));
            q_reg[wp_reg].last  <= item.last_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (acc) wp_reg <= wp_reg + 1'b1;
            if (cmd_take && cmd_valid) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(acc) - 2'(cmd_take && cmd_valid);
        end
    end
endmodule

// ----- rtl/pts_div.sv -----
// ----------------------------------------------------------------------------
// Tridiagonal solver divider
// Serial restoring divider giving a rounded, saturated Q4.28 quotient.
// ----------------------------------------------------------------------------
module pts_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [33:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    import pts_pkg::*;

    // The quotient of |num| << 28 by |den| needs at most 61 bits; one guard bit rounds.
    localparam int QB = 63;

    logic [61:0] dividend_reg;
    logic [31:0] den_reg;
    logic [32:0] rem_reg;
    logic [QB-1:0] q_reg;
    logic [6:0]  step_reg;
    logic        busy_reg, neg_reg, zero_reg, nz_reg, nsign_reg;
    logic [33:0] mag_num;
    logic [32:0] trial;
    logic [33:0] rem_sh;
    logic [QB-1:0] qr;
    logic [QB-2:0] qm;

    assign mag_num = num[33] ? 34'(-num) : 34'(num);
    assign rem_sh  = {rem_reg, dividend_reg[61]};
    assign trial   = 33'(rem_sh - {2'b00, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == 7'(QB - 2))
            begin
                busy_reg <= 1'b0;
                done     <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= {mag_num[32:0], 29'd0};
            den_reg      <= den[31] ? 32'(-den) : 32'(den);
            rem_reg      <= '0;
            q_reg        <= '0;
            step_reg     <= '0;
            neg_reg      <= num[33] ^ den[31];
            zero_reg     <= (den == '0);
            nz_reg       <= (num == '0);
            nsign_reg    <= num[33];
        end
        else if (busy_reg)
        begin
            dividend_reg <= {dividend_reg[60:0], 1'b0};
            step_reg     <= step_reg + 1'b1;
            if (rem_sh >= {2'b00, den_reg})
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[32:0];
                q_reg   <= {q_reg[QB-2:0], 1'b0};
            end
        end
    end

    assign qr = q_reg + QB'(1);
    assign qm = qr[QB-1:1];

    always_comb
    begin
        if (zero_reg)
        begin
            if (nz_reg) quo = '0;
            else quo = nsign_reg ? Q_MIN : Q_MAX;
        end
        else if (neg_reg)
        begin
            if (qm > 62'd2147483648) quo = Q_MIN;
            else quo = 32'(-$signed({1'b0, qm}));
        end
        else
        begin
            if (qm > 62'd2147483647) quo = Q_MAX;
            else quo = qm[31:0];
        end
    end
endmodule

// ----- rtl/pts_back.sv -----
// ----------------------------------------------------------------------------
// Tridiagonal solver back end
// Runs the forward sweep into the stores and the back substitution out.
// ----------------------------------------------------------------------------
module pts_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pts_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_take,
    output pts_pkg::out_item_t res,
    output logic               empty,
    input  logic               pop
);
    import pts_pkg::*;

    state_t state_reg, state_next;
    logic signed [31:0] diag_mem [MAX_POINTS];
    logic signed [31:0] rhs_mem  [MAX_POINTS];
    logic signed [31:0] d_rd_reg, k_rd_reg, d_new_reg, v_reg, b_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   p_reg;
    logic               last_reg, st_reg, out_valid_reg;
    logic               div_start, div_done;
    logic signed [33:0] div_num;
    logic signed [31:0] div_den, quo;
    logic signed [31:0] wr_d, wr_k;

    pts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    assign empty = !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                begin
                    if (cmd.store && cnt_reg != '0) state_next = ST_DIV_D;
                    else state_next = ST_WRITE;
                end
            ST_DIV_D:      if (div_done) state_next = ST_DIV_K;
            ST_DIV_K:      if (div_done) state_next = ST_WRITE;
            ST_WRITE:      state_next = last_reg ? ST_BACK_RD : ST_IDLE;
            ST_BACK_RD:    state_next = ST_BACK_START;
            ST_BACK_START: state_next = ST_BACK_DIV;
            ST_BACK_DIV:   if (div_done) state_next = ST_BACK_OUT;
            ST_BACK_OUT:
                if (!out_valid_reg)
                    state_next = (p_reg == '0) ? ST_IDLE : ST_BACK_RD;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_take  = (state_reg == ST_IDLE) && cmd_valid;
        div_start = 1'b0;
        div_num   = 34'(signed'(Q_ONE));
        div_den   = d_rd_reg;
        case (state_reg)
            ST_IDLE:     div_start = cmd_valid && cmd.store && cnt_reg != '0;
            ST_DIV_D:
            begin
                div_num   = 34'(k_rd_reg);
                div_start = div_done;
            end
            ST_BACK_START:
            begin
                div_num   = 34'(k_rd_reg) + 34'(v_reg);
                div_start = 1'b1;
            end
            default:     div_start = 1'b0;
        endcase
    end

    assign wr_d = (cnt_reg == '0) ? Q_TWO : d_new_reg;
    assign wr_k = (cnt_reg == '0) ? b_reg : sat34(34'(b_reg) + 34'(quo));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
            b_reg <= cmd.rhs;
        if (state_reg == ST_DIV_D && div_done)
            d_new_reg <= sat34(34'(signed'(Q_TWO)) - 34'(quo));
        if (state_reg == ST_WRITE && st_reg)
        begin
            diag_mem[cnt_reg[IDX_W-1:0]] <= wr_d;
            rhs_mem[cnt_reg[IDX_W-1:0]]  <= wr_k;
            d_rd_reg <= wr_d;
            k_rd_reg <= wr_k;
        end
        if (state_reg == ST_BACK_RD)
        begin
            d_rd_reg <= diag_mem[p_reg];
            k_rd_reg <= rhs_mem[p_reg];
        end
        if (state_reg == ST_BACK_DIV && div_done)
        begin
            res.solution_value <= quo;
            res.last_value     <= (p_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            p_reg         <= '0;
            v_reg         <= '0;
            last_reg      <= 1'b0;
            st_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && pop) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (cmd_valid)
                    begin
                        last_reg <= cmd.last;
                        st_reg   <= cmd.store;
                    end
                ST_WRITE:
                begin
                    if (st_reg)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        p_reg   <= cnt_reg[IDX_W-1:0];
                    end
                    else
                        p_reg <= IDX_W'(cnt_reg - 1'b1);
                    v_reg <= '0;
                end
                ST_BACK_DIV:
                    if (div_done)
                    begin
                        v_reg         <= quo;
                        out_valid_reg <= 1'b1;
                    end
                ST_BACK_OUT:
                    if (!out_valid_reg)
                    begin
                        if (p_reg == '0)
                        begin
                            cnt_reg <= '0;
                            p_reg   <= '0;
                        end
                        else p_reg <= p_reg - 1'b1;
                    end
                default: ;
            endcase
            if (state_reg == ST_IDLE && cmd_valid && cnt_reg != '0)
                p_reg <= IDX_W'(cnt_reg - 1'b1);
        end
    end
endmodule

// ----- rtl/poisson_tridiagonal_solver_top.sv -----
// Forward step: two 62-step serial divisions per stored sample after the first of a system.
// Back substitution: one serial division per result; the next waits until the last is taken.
// A two-entry command queue decouples sample intake from the sweep unit.
// Reset is asynchronous; stores hold no reset value and are written first.
// ----------------------------------------------------------------------------
// Poisson tridiagonal solver
// Streaming Thomas solver for the 1D Poisson system in Q4.28.
// ----------------------------------------------------------------------------
module poisson_tridiagonal_solver_top (
    input  logic               clk,
    input  logic               rst_n,
    input  pts_pkg::in_item_t  in_item,
    input  logic               push,
    output logic               full,
    output pts_pkg::out_item_t out_item,
    output logic               empty,
    input  logic               pop
);
    import pts_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_take;

    pts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_item),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    pts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .res       (out_item),
        .empty     (empty),
        .pop       (pop)
    );

    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid) else $error("command taken from empty queue");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("waiting result changed");

endmodule

// ----- tb/tb_poisson_tridiagonal_solver_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Poisson tridiagonal solver testbench
// Sends right-hand-side samples in systems of random length, predicts the
// back-substituted solution of every system and checks each result transfer
// in order, under random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_poisson_tridiagonal_solver_top;

    import pts_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;

    class solution_scoreboard;
        logic signed [31:0] diag_mem [MAX_POINTS];
        logic signed [31:0] rhs_mem [MAX_POINTS];
        int                 points;
        out_item_t          pending [$];
        int                 errors;

        function new();
            points = 0;
            errors = 0;
        endfunction

        function automatic logic signed [31:0] sat(longint v);
            if (v > 64'sd2147483647) return Q_MAX;
            if (v < -64'sd2147483648) return Q_MIN;
            return v[31:0];
        endfunction

        function automatic logic signed [31:0] qdiv(longint num, longint den);
            bit     neg;
            longint mn;
            longint md;
            longint q;
            neg = (num < 0) != (den < 0);
            mn = num < 0 ? -num : num;
            md = den < 0 ? -den : den;
            if (md == 0)
            begin
                if (num == 0) return 0;
                return num > 0 ? Q_MAX : Q_MIN;
            end
            q = ((mn <<< FRAC_BITS) + md / 2) / md;
            if (neg) return sat(-q);
            return sat(q);
        endfunction

        function void note_sample(in_item_t it);
            longint    v;
            out_item_t r;
            if (points < MAX_POINTS)
            begin
                if (points == 0)
                begin
                    diag_mem[0] = Q_TWO;
                    rhs_mem[0] = it.rhs_sample;
                end
                else
                begin
                    diag_mem[points] = sat(longint'(Q_TWO) -
                        longint'(qdiv(longint'(Q_ONE), diag_mem[points-1])));
                    rhs_mem[points] = sat(longint'(it.rhs_sample) +
                        longint'(qdiv(rhs_mem[points-1], diag_mem[points-1])));
                end
                points++;
            end
            if (!it.last_sample) return;
            v = 0;
            for (int p = points - 1; p >= 0; p--)
            begin
                v = qdiv(longint'(rhs_mem[p]) + v, diag_mem[p]);
                r.solution_value = v[31:0];
                r.last_value = (p == 0);
                pending.push_back(r);
            end
            points = 0;
        endfunction

        task report_mismatch(string what, longint want, longint got);
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
            errors++;
        endtask

        task check_solution(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 0, got.solution_value);
                return;
            end
            want = pending.pop_front();
            if (got.solution_value !== want.solution_value)
                report_mismatch("solution_value", want.solution_value, got.solution_value);
            if (got.last_value !== want.last_value)
                report_mismatch("last_value", want.last_value, got.last_value);
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    in_item_t  in_item;
    logic      push;
    logic      full;
    out_item_t out_item;
    logic      empty;
    logic      pop;

    solution_scoreboard sb;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles;
    longint cycle_count;

    poisson_tridiagonal_solver_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .push     (push),
        .full     (full),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_item = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        cycle_count = 0;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("poisson_tridiagonal_solver_top verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_solution(out_item);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_sample(logic signed [31:0] value, logic is_last);
        in_item_t it;
        it.rhs_sample = value;
        it.last_sample = is_last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_sample(it);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return $urandom;
            default: return $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
        endcase
    endfunction

    task automatic send_system(int len);
        for (int i = 0; i < len; i++)
            send_sample(random_value(), i == len - 1);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int len;
        @(posedge rst_n);
        @(posedge clk);
        send_sample(Q_MAX, 1'b0);
        send_sample(Q_MIN, 1'b1);
        send_sample(32'sd0, 1'b1);
        send_sample(Q_MIN, 1'b0);
        send_sample(Q_MIN, 1'b0);
        send_sample(Q_MAX, 1'b1);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b0);
        send_sample(Q_ONE, 1'b1);
        wait_drained();
        // Overfill one system so samples past the store size are dropped.
        send_system(MAX_POINTS + 2);
        wait_drained();
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = phase == 0 ? 10 : (phase == 1 ? 67 : 0);
            recv_idle_pct = phase == 0 ? 67 : (phase == 1 ? 10 : 0);
            if (phase == 2)
                hold_cycles <= 3000;
            for (int s = 0; s < 12; s += len)
            begin
                len = $urandom_range(7) == 0 ? $urandom_range(MAX_POINTS, 2)
                                             : $urandom_range(8, 1);
                send_system(len);
            end
            wait_drained();
        end
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("poisson_tridiagonal_solver_top verification clean");
        else
            $display("poisson_tridiagonal_solver_top verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pts_pkg.sv
rtl/pts_front.sv
rtl/pts_div.sv
rtl/pts_back.sv
rtl/poisson_tridiagonal_solver_top.sv
tb/tb_poisson_tridiagonal_solver_top.sv
